/* sv/wavetable_tone_resampler_core_macros.svh */
// Assertion helpers for the tone resampler core.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef WAVETABLE_TONE_RESAMPLER_CORE_MACROS_SVH
`define WAVETABLE_TONE_RESAMPLER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WTR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wtr_pkg.sv */
// ----------------------------------------------------------------------------
// wtr_pkg
// Shared types and fixed constants of the wavetable tone resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wtr_pkg;

    localparam int unsigned PHASE_STEP   = 111844;
    localparam logic [3:0]  SILENT_ATTEN = 4'hF;
    localparam int unsigned BASE_W       = 16;
    localparam logic [15:0] BASE_RESET   = 16'd105;
    localparam int unsigned LENGTH_RESET = 420;
    localparam int unsigned ATTEN_W      = 4;
    localparam int unsigned SAMPLE_W     = 16;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned Q_DEPTH      = 2;

    // advances per sample stay below 2^ADV_W; one extra bit covers pos + adv
    localparam int unsigned ADV_W    = $clog2(PHASE_STEP + 2);
    localparam int unsigned DIV_BITS = ADV_W + 1;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_SILENT,
        CMD_TONE
    } cmd_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE   = 2'd0,
        REG_LENGTH = 2'd1,
        REG_MIX    = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CALC,
        B_DIV_CNT,
        B_DIV_POS,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic      valid;
        cmd_kind_t kind;
        logic      last;
    } q_head_t;

    typedef struct packed {
        logic busy;
        logic emitting;
    } back_stat_t;

endpackage

`default_nettype wire

/* sv/wtr_divider.sv */
// ----------------------------------------------------------------------------
// wtr_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wtr_divider
    import wtr_pkg::*;
#(
    parameter int unsigned DIV_W = 26,
    parameter int unsigned NB    = 18
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] rem_init,
    input  wire logic [NB-1:0]    bits_init,
    input  wire logic [DIV_W-1:0] divisor,
    output logic                  done,
    output logic [NB-1:0]         quot,
    output logic [DIV_W-1:0]      rem
);

    localparam int unsigned STEP_W = $clog2(NB + 1);

    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  rem_next;
    logic [NB-1:0]     bits_reg;
    logic [NB-1:0]     bits_next;
    logic [DIV_W-1:0]  div_reg;
    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;
    logic              fits;

    // partial remainder always stays below the divisor
    assign shifted   = {rem_reg, bits_reg[NB-1]};
    assign fits      = shifted >= {1'b0, div_reg};
    assign diff      = shifted - {1'b0, div_reg};
    assign rem_next  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    assign bits_next = {bits_reg[NB-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == STEP_W'(1));
            if (start)
            begin
                step_reg <= STEP_W'(NB);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            bits_reg <= bits_init;
            div_reg  <= divisor;
        end
        else if (step_reg != '0)
        begin
            rem_reg  <= rem_next;
            bits_reg <= bits_next;
        end
    end

    assign done = done_reg;
    assign quot = bits_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

/* sv/wtr_front.sv */
// ----------------------------------------------------------------------------
// wtr_front
// Input side: classifies each transfer and buffers it in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wtr_front
    import wtr_pkg::*;
#(
    parameter int unsigned WAVE_DEPTH = 512,
    parameter int unsigned FREQ_CODES = 1024
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          req_type,
    input  wire logic [$clog2(WAVE_DEPTH)-1:0] wave_index,
    input  wire logic signed [SAMPLE_W-1:0]    wave_value,
    input  wire logic [$clog2(FREQ_CODES)-1:0] freq_code,
    input  wire logic [ATTEN_W-1:0]            attenuation,
    input  wire logic signed [SAMPLE_W-1:0]    mix_in,
    input  wire logic                          last_of_call,
    input  wire logic                          pop,
    output q_head_t                            head,
    output logic [$clog2(WAVE_DEPTH)-1:0]      head_index,
    output logic [SAMPLE_W-1:0]                head_value,
    output logic [$clog2(FREQ_CODES)-1:0]      head_code,
    output logic [SAMPLE_W-1:0]                head_mix
);

    localparam int unsigned POS_W  = $clog2(WAVE_DEPTH);
    localparam int unsigned CODE_W = $clog2(FREQ_CODES);
    localparam int unsigned PTR_W  = $clog2(Q_DEPTH);
    localparam int unsigned CNT_W  = $clog2(Q_DEPTH + 1);

    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              code_ok;
    logic              silent;
    cmd_kind_t         kind;
    logic [CODE_W-1:0] code_norm;

    cmd_kind_t         kind_q  [Q_DEPTH];
    logic              last_q  [Q_DEPTH];
    logic [POS_W-1:0]  index_q [Q_DEPTH];
    logic [SAMPLE_W-1:0] value_q [Q_DEPTH];
    logic [CODE_W-1:0] code_q  [Q_DEPTH];
    logic [SAMPLE_W-1:0] mix_q [Q_DEPTH];

    // out-of-range codes count as silent and are stored as zero
    assign code_ok   = {1'b0, freq_code} < (CODE_W + 1)'(FREQ_CODES);
    assign silent    = (freq_code == '0) || !code_ok || (attenuation >= SILENT_ATTEN);
    assign code_norm = code_ok ? freq_code : '0;

    always_comb
    begin
        if (!req_type)
        begin
            kind = CMD_LOAD;
        end
        else if (silent)
        begin
            kind = CMD_SILENT;
        end
        else
        begin
            kind = CMD_TONE;
        end
    end

    assign in_stall = (count_reg == CNT_W'(Q_DEPTH));
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_q[wr_ptr_reg]  <= kind;
            last_q[wr_ptr_reg]  <= last_of_call;
            index_q[wr_ptr_reg] <= wave_index;
            value_q[wr_ptr_reg] <= wave_value;
            code_q[wr_ptr_reg]  <= code_norm;
            mix_q[wr_ptr_reg]   <= mix_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.kind  = kind_q[rd_ptr_reg];
    assign head.last  = last_q[rd_ptr_reg];
    assign head_index = index_q[rd_ptr_reg];
    assign head_value = value_q[rd_ptr_reg];
    assign head_code  = code_q[rd_ptr_reg];
    assign head_mix   = mix_q[rd_ptr_reg];

endmodule

`default_nettype wire

/* sv/wtr_back.sv */
// ----------------------------------------------------------------------------
// wtr_back
// Execution side: wave store, phase accumulator, position update, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wtr_back
    import wtr_pkg::*;
#(
    parameter int unsigned WAVE_DEPTH = 512,
    parameter int unsigned FREQ_CODES = 1024
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire q_head_t                            head,
    input  wire logic [$clog2(WAVE_DEPTH)-1:0]      head_index,
    input  wire logic [SAMPLE_W-1:0]                head_value,
    input  wire logic [$clog2(FREQ_CODES)-1:0]      head_code,
    input  wire logic [SAMPLE_W-1:0]                head_mix,
    output logic                                    pop,
    input  wire logic [BASE_W-1:0]                  base_frequency,
    input  wire logic [$clog2(WAVE_DEPTH + 1)-1:0]  wave_length,
    input  wire logic                               mix_mode,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [SAMPLE_W-1:0]              out_sample,
    output logic                                    last_out,
    output back_stat_t                              stat
);

    localparam int unsigned POS_W   = $clog2(WAVE_DEPTH);
    localparam int unsigned LEN_W   = $clog2(WAVE_DEPTH + 1);
    localparam int unsigned CODE_W  = $clog2(FREQ_CODES);
    localparam int unsigned SCALE_W = BASE_W + CODE_W;
    localparam int unsigned CNT_W   = SCALE_W + 1;

    back_state_t state_reg;
    back_state_t state_next;

    logic [SCALE_W-1:0]  count_reg;
    logic [SCALE_W-1:0]  count_next;
    logic [SCALE_W-1:0]  scale_reg;
    logic [SCALE_W-1:0]  scale_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [CODE_W-1:0]   prev_reg;
    logic [CODE_W-1:0]   prev_next;
    logic [SAMPLE_W-1:0] mix_reg;
    logic [SAMPLE_W-1:0] mix_next;
    logic                last_reg;
    logic                last_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] sample_next;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic [SAMPLE_W-1:0] out_sample_next;
    logic                last_out_reg;
    logic                last_out_next;

    logic [SAMPLE_W-1:0] mem [WAVE_DEPTH];

    logic [LEN_W-1:0]    used_len;
    logic [CNT_W-1:0]    cnt;
    logic                code_change;
    logic                rewind;
    logic [POS_W-1:0]    rd_addr;
    logic                mem_we;
    logic                out_free;
    logic                pos_beyond;
    logic [SCALE_W-1:0]  product;
    logic [DIV_BITS-1:0] pos_dividend;

    logic                div_start;
    logic [SCALE_W-1:0]  div_rem_init;
    logic [DIV_BITS-1:0] div_bits_init;
    logic [SCALE_W-1:0]  div_divisor;
    logic                div_done;
    logic [DIV_BITS-1:0] div_quot;
    logic [SCALE_W-1:0]  div_rem;

    always_comb
    begin
        used_len = wave_length;
        if (wave_length == '0)
        begin
            used_len = LEN_W'(1);
        end
        else if (wave_length > LEN_W'(WAVE_DEPTH))
        begin
            used_len = LEN_W'(WAVE_DEPTH);
        end
    end

    // count stays below the scale, so cnt never overflows CNT_W
    assign cnt         = {1'b0, count_reg} + CNT_W'(PHASE_STEP);
    assign code_change = (head_code != prev_reg);
    assign rewind      = code_change && (prev_reg == '0);
    assign rd_addr     = rewind ? '0 : pos_reg;
    assign pop         = head.valid && (state_reg == B_IDLE);
    assign mem_we      = pop && (head.kind == CMD_LOAD)
                         && ({1'b0, head_index} < (POS_W + 1)'(WAVE_DEPTH));
    assign out_free    = !out_valid_reg || !out_stall;
    assign pos_beyond  = LEN_W'(pos_reg) >= used_len;
    assign product     = SCALE_W'(base_frequency) * SCALE_W'(head_code);

    // stale position: first advance lands on zero
    assign pos_dividend = pos_beyond ? (div_quot - DIV_BITS'(1))
                                     : (DIV_BITS'(pos_reg) + div_quot);

    wtr_divider #(
        .DIV_W (SCALE_W),
        .NB    (DIV_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .rem_init  (div_rem_init),
        .bits_init (div_bits_init),
        .divisor   (div_divisor),
        .done      (div_done),
        .quot      (div_quot),
        .rem       (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    unique case (head.kind)
                        CMD_SILENT: state_next = B_EMIT;
                        CMD_TONE:   state_next = B_CALC;
                        default:    state_next = B_IDLE;
                    endcase
                end
            end
            B_CALC:
            begin
                state_next = (scale_reg == '0) ? B_EMIT : B_DIV_CNT;
            end
            B_DIV_CNT:
            begin
                if (div_done)
                begin
                    state_next = (div_quot == '0) ? B_EMIT : B_DIV_POS;
                end
            end
            B_DIV_POS:
            begin
                if (div_done)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        scale_next      = scale_reg;
        pos_next        = pos_reg;
        prev_next       = prev_reg;
        mix_next        = mix_reg;
        last_next       = last_reg;
        sample_next     = sample_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_sample_next = out_sample_reg;
        last_out_next   = last_out_reg;
        div_start       = 1'b0;
        div_rem_init    = '0;
        div_bits_init   = pos_dividend;
        div_divisor     = SCALE_W'(used_len);

        unique case (state_reg)
            B_IDLE:
            begin
                if (head.valid && (head.kind == CMD_SILENT))
                begin
                    count_next  = '0;
                    pos_next    = '0;
                    prev_next   = mix_mode ? head_code : '0;
                    sample_next = mix_mode ? head_mix : '0;
                    last_next   = head.last;
                end
                else if (head.valid && (head.kind == CMD_TONE))
                begin
                    if (code_change)
                    begin
                        count_next = '0;
                        scale_next = product;
                        prev_next  = head_code;
                    end
                    pos_next  = rd_addr;
                    mix_next  = head_mix;
                    last_next = head.last;
                end
            end
            B_CALC:
            begin
                sample_next = mix_mode ? (rd_data_reg + mix_reg) : rd_data_reg;
                if (scale_reg == '0)
                begin
                    count_next = '0;
                end
                else
                begin
                    // high part of cnt is already below the scale
                    div_start     = 1'b1;
                    div_rem_init  = SCALE_W'(cnt >> DIV_BITS);
                    div_bits_init = cnt[DIV_BITS-1:0];
                    div_divisor   = scale_reg;
                end
            end
            B_DIV_CNT:
            begin
                if (div_done)
                begin
                    count_next = div_rem;
                    div_start  = (div_quot != '0);
                end
            end
            B_DIV_POS:
            begin
                if (div_done)
                begin
                    pos_next = div_rem[POS_W-1:0];
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = sample_reg;
                    last_out_next   = last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            scale_reg     <= '0;
            pos_reg       <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            scale_reg     <= scale_next;
            pos_reg       <= pos_next;
            prev_reg      <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg        <= mix_next;
        last_reg       <= last_next;
        sample_reg     <= sample_next;
        out_sample_reg <= out_sample_next;
        last_out_reg   <= last_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[head_index] <= head_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign out_valid     = out_valid_reg;
    assign out_sample    = out_sample_reg;
    assign last_out      = last_out_reg;
    assign stat.busy     = (state_reg != B_IDLE);
    assign stat.emitting = (state_reg == B_EMIT);

endmodule

`default_nettype wire

/* sv/wavetable_tone_resampler_core.sv */
// ----------------------------------------------------------------------------
// wavetable_tone_resampler_core
// Wavetable tone channel: phase accumulator stepping through a loaded wave.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  req_type, wave_index, wave_value,
//                                          freq_code, attenuation, mix_in,
//                                          last_of_call
//   out      source     out_valid/out_stall out_sample, last_out
//   cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// Back end: a load is written to the wave store as it pops; silent ticks go to
// emit; an audible tick runs calc, the one-bit-per-cycle divider splitting the
// phase, a divide wrapping a moved position, and emit; zero scale skips both.
// A two-entry queue takes input transfers while the back end works.
// Output is registered; a stalled output holds the back end in its last step.
// rst_n is asynchronous; the wave store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "wavetable_tone_resampler_core_macros.svh"

module wavetable_tone_resampler_core
    import wtr_pkg::*;
#(
    parameter int unsigned WAVE_DEPTH = 512,
    parameter int unsigned FREQ_CODES = 1024
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          req_type,
    input  wire logic [$clog2(WAVE_DEPTH)-1:0] wave_index,
    input  wire logic signed [SAMPLE_W-1:0]    wave_value,
    input  wire logic [$clog2(FREQ_CODES)-1:0] freq_code,
    input  wire logic [ATTEN_W-1:0]            attenuation,
    input  wire logic signed [SAMPLE_W-1:0]    mix_in,
    input  wire logic                          last_of_call,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_W-1:0]         out_sample,
    output logic                               last_out,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int unsigned POS_W  = $clog2(WAVE_DEPTH);
    localparam int unsigned LEN_W  = $clog2(WAVE_DEPTH + 1);
    localparam int unsigned CODE_W = $clog2(FREQ_CODES);

    logic [BASE_W-1:0]   base_reg;
    logic [LEN_W-1:0]    length_reg;
    logic                mix_mode_reg;
    logic                cfg_we;

    q_head_t             q_head;
    logic [POS_W-1:0]    head_index;
    logic [SAMPLE_W-1:0] head_value;
    logic [CODE_W-1:0]   head_code;
    logic [SAMPLE_W-1:0] head_mix;
    logic                pop;
    back_stat_t          bk_stat;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= BASE_RESET;
            length_reg   <= LEN_W'(LENGTH_RESET);
            mix_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BASE:   base_reg     <= cfg_data[BASE_W-1:0];
                REG_LENGTH: length_reg   <= cfg_data[LEN_W-1:0];
                REG_MIX:    mix_mode_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    wtr_front #(
        .WAVE_DEPTH (WAVE_DEPTH),
        .FREQ_CODES (FREQ_CODES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .wave_index   (wave_index),
        .wave_value   (wave_value),
        .freq_code    (freq_code),
        .attenuation  (attenuation),
        .mix_in       (mix_in),
        .last_of_call (last_of_call),
        .pop          (pop),
        .head         (q_head),
        .head_index   (head_index),
        .head_value   (head_value),
        .head_code    (head_code),
        .head_mix     (head_mix)
    );

    wtr_back #(
        .WAVE_DEPTH (WAVE_DEPTH),
        .FREQ_CODES (FREQ_CODES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (q_head),
        .head_index     (head_index),
        .head_value     (head_value),
        .head_code      (head_code),
        .head_mix       (head_mix),
        .pop            (pop),
        .base_frequency (base_reg),
        .wave_length    (length_reg),
        .mix_mode       (mix_mode_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_sample     (out_sample),
        .last_out       (last_out),
        .stat           (bk_stat)
    );

    `WTR_ASSERT_NOW(a_full_has_head, in_stall, q_head.valid, "queue full without head entry")
    `WTR_ASSERT_NOW(a_pop_needs_head, pop, q_head.valid, "pop from empty queue")
    `WTR_ASSERT_NEXT(a_tick_leaves_idle, pop && (q_head.kind != CMD_LOAD), bk_stat.busy, "tick did not start back end")
    `WTR_ASSERT_NEXT(a_out_from_emit, !out_valid && !bk_stat.emitting, !out_valid, "output raised outside emit step")

endmodule

`default_nettype wire

/* sim/tb_wavetable_tone_resampler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wavetable_tone_resampler_core
// Self-checking bench for the wavetable tone channel.
// Loads the whole wave store, runs directed ticks for silence, code changes,
// add-mode wraparound, length limits, stale positions and a zero step scale,
// then random buffer fills under several register settings. A local mirror of
// the phase accumulator predicts each sample, and a monitor compares every
// output transfer against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_wavetable_tone_resampler_core;
    import wtr_pkg::*;

    localparam int WAVE_DEPTH     = 512;
    localparam int FREQ_CODES     = 1024;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 55;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic MIX_REPLACE = 1'b0;
    localparam logic MIX_ADD     = 1'b1;

    typedef enum bit {
        REQ_LOAD = 1'b0,
        REQ_TICK = 1'b1
    } req_kind_t;

    typedef struct {
        req_kind_t          kind;
        logic [8:0]         index;
        logic signed [15:0] value;
        logic [9:0]         code;
        logic [3:0]         atten;
        logic signed [15:0] mix;
        logic               last;
    } tone_req_t;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } tone_out_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   req_type;
    logic [8:0]             wave_index;
    logic signed [15:0]     wave_value;
    logic [9:0]             freq_code;
    logic [3:0]             attenuation;
    logic signed [15:0]     mix_in;
    logic                   last_of_call;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [15:0]     out_sample;
    logic                   last_out;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // channel mirror
    logic [15:0] wave_mem [0:WAVE_DEPTH-1];
    logic [31:0] acc_phase;
    logic [25:0] acc_scale;
    logic [8:0]  wave_pos;
    logic [9:0]  held_code;
    logic [15:0] cfg_base;
    logic [9:0]  cfg_length;
    logic        cfg_mix;

    tone_out_t pending_samples[$];
    int        fail_count;
    bit        idle_en;

    wavetable_tone_resampler_core #(
        .WAVE_DEPTH (WAVE_DEPTH),
        .FREQ_CODES (FREQ_CODES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .wave_index   (wave_index),
        .wave_value   (wave_value),
        .freq_code    (freq_code),
        .attenuation  (attenuation),
        .mix_in       (mix_in),
        .last_of_call (last_of_call),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_sample   (out_sample),
        .last_out     (last_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the mirror by one accepted request; ticks queue one sample.
    task automatic apply_request(input tone_req_t r);
        tone_out_t   o;
        logic [32:0] total;
        logic [32:0] steps;
        logic [9:0]  len;
        if (r.kind == REQ_LOAD)
        begin
            wave_mem[r.index] = r.value;
            return;
        end
        o.last = r.last;
        if (r.code == 0 || r.code >= FREQ_CODES || r.atten >= SILENT_ATTEN)
        begin
            acc_phase = '0;
            wave_pos  = '0;
            held_code = (cfg_mix == MIX_ADD) ? r.code : '0;
            o.sample  = (cfg_mix == MIX_ADD) ? r.mix : '0;
        end
        else
        begin
            if (r.code != held_code)
            begin
                acc_phase = '0;
                acc_scale = cfg_base * r.code;
                if (held_code == 0)
                    wave_pos = '0;
                held_code = r.code;
            end
            o.sample = wave_mem[wave_pos];
            if (cfg_mix == MIX_ADD)
                o.sample = o.sample + r.mix;
            total = {1'b0, acc_phase} + PHASE_STEP;
            if (acc_scale == 0)
                acc_phase = '0;
            else
            begin
                steps     = total / acc_scale;
                acc_phase = 32'(total % acc_scale);
                len = (cfg_length == 0) ? 10'd1
                    : (cfg_length > WAVE_DEPTH) ? 10'(WAVE_DEPTH) : cfg_length;
                if (steps != 0)
                begin
                    // a position past the length restarts from entry 0
                    if (wave_pos >= len)
                        wave_pos = 9'((steps - 1) % len);
                    else
                        wave_pos = 9'((wave_pos + steps) % len);
                end
            end
        end
        pending_samples.push_back(o);
    endtask

    function automatic tone_req_t random_request();
        tone_req_t r;
        r.kind  = req_kind_t'($urandom_range(0, 1));
        r.index = 9'($urandom);
        r.value = 16'($urandom);
        r.code  = 10'($urandom);
        r.atten = 4'($urandom);
        r.mix   = 16'($urandom);
        r.last  = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic tone_req_t tone_tick(input logic [9:0] code, input logic [3:0] atten,
                                            input logic signed [15:0] mix, input logic last);
        tone_req_t r;
        r       = random_request();
        r.kind  = REQ_TICK;
        r.code  = code;
        r.atten = atten;
        r.mix   = mix;
        r.last  = last;
        return r;
    endfunction

    function automatic tone_req_t wave_load(input logic [8:0] index,
                                            input logic signed [15:0] value);
        tone_req_t r;
        r       = random_request();
        r.kind  = REQ_LOAD;
        r.index = index;
        r.value = value;
        return r;
    endfunction

    function automatic logic [9:0] pick_code();
        case ($urandom_range(0, 4))
            0: return 10'($urandom_range(1, 8));
            1: return 10'($urandom_range(960, FREQ_CODES - 1));
            2: return '0;
            default: return 10'($urandom_range(1, FREQ_CODES - 1));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    // in_valid is left high so back-to-back items need no toggle.
    task automatic send_request(input tone_req_t r);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= r.kind;
        wave_index   <= r.index;
        wave_value   <= r.value;
        freq_code    <= r.code;
        attenuation  <= r.atten;
        mix_in       <= r.mix;
        last_of_call <= r.last;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        apply_request(r);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        case (idx)
            REG_BASE:   cfg_base = data;
            REG_LENGTH: cfg_length = data[9:0];
            REG_MIX:    cfg_mix = data[0];
            default:    ;
        endcase
    endtask

    // Wait for every expected sample, then give trailing loads time to retire.
    task automatic settle_channel();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] base, input logic [15:0] length,
                                  input logic mix);
        settle_channel();
        write_register(REG_SPARE, 16'($urandom));
        write_register(REG_BASE, base);
        write_register(REG_LENGTH, length);
        write_register(REG_MIX, {15'd0, mix});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_wave_fill();
        for (int i = 0; i < WAVE_DEPTH; i++)
            send_request(wave_load(9'(i), 16'($urandom)));
    endtask

    task automatic test_reset_settings();
        send_request(tone_tick(10'd1, 4'd0, 16'sd0, 1'b0));
        send_request(tone_tick(10'd1, 4'd0, -16'sd1, 1'b1));
        // code change from a sounding code keeps the position
        send_request(tone_tick(10'd1023, 4'd14, 16'sd32767, 1'b0));
        send_request(tone_tick(10'd0, 4'd5, -16'sd32768, 1'b0));
        send_request(tone_tick(10'd12, SILENT_ATTEN, 16'sd0, 1'b1));
        send_request(tone_tick(10'd5, 4'd0, 16'sd0, 1'b1));
    endtask

    task automatic test_mix_add();
        apply_settings(16'd105, 16'd420, MIX_ADD);
        send_request(wave_load(9'd0, 16'sd32767));
        send_request(wave_load(9'd511, -16'sd32768));
        send_request(tone_tick(10'd0, 4'd0, -16'sd1, 1'b0));
        send_request(tone_tick(10'd3, 4'd0, 16'sd32767, 1'b0));
        // silenced by attenuation in add mode: code is held, scale is not reloaded
        send_request(tone_tick(10'd3, SILENT_ATTEN, -16'sd32768, 1'b0));
        send_request(tone_tick(10'd3, 4'd2, 16'sd0, 1'b1));
    endtask

    task automatic test_stale_position();
        apply_settings(16'd1, 16'd512, MIX_REPLACE);
        send_request(tone_tick(10'd0, 4'd0, 16'sd0, 1'b0));
        send_request(tone_tick(10'd1000, 4'd0, 16'sd0, 1'b0));
        send_request(tone_tick(10'd1000, 4'd0, 16'sd0, 1'b1));
        // shrink the length below the current position
        apply_settings(16'd1, 16'd16, MIX_REPLACE);
        send_request(tone_tick(10'd1000, 4'd0, 16'sd0, 1'b1));
    endtask

    task automatic test_length_limits();
        apply_settings(16'd105, 16'd0, MIX_REPLACE);
        send_request(tone_tick(10'd2, 4'd0, 16'sd0, 1'b0));
        send_request(tone_tick(10'd2, 4'd0, 16'sd0, 1'b1));
        apply_settings(16'd40, 16'd1023, MIX_ADD);
        send_request(tone_tick(10'd1, 4'd0, 16'sd100, 1'b0));
        send_request(tone_tick(10'd1, 4'd0, -16'sd100, 1'b1));
    endtask

    task automatic test_zero_scale();
        apply_settings(16'd0, 16'd7, MIX_ADD);
        send_request(tone_tick(10'd7, 4'd0, 16'sd1, 1'b0));
        send_request(tone_tick(10'd7, 4'd0, 16'sd2, 1'b0));
        send_request(tone_tick(10'd9, 4'd3, 16'sd3, 1'b1));
    endtask

    // Mostly buffer fills of one code, with loads and unstructured noise mixed in.
    task automatic run_tone_traffic(input int count);
        int         sent;
        int         call_len;
        logic [9:0] code;
        logic [3:0] atten;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    send_request(wave_load(9'($urandom), 16'($urandom)));
                    sent++;
                end
                1:
                begin
                    send_request(random_request());
                    sent++;
                end
                default:
                begin
                    call_len = $urandom_range(1, 24);
                    code     = pick_code();
                    atten    = 4'($urandom_range(0, 14));
                    for (int i = 0; i < call_len; i++)
                    begin
                        send_request(tone_tick(code,
                            ($urandom_range(0, 19) == 0) ? SILENT_ATTEN : atten,
                            16'($urandom), i == call_len - 1));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: apply_settings(BASE_RESET, 16'(LENGTH_RESET), MIX_REPLACE);
                1: apply_settings(16'd1, 16'd512, MIX_ADD);
                2: apply_settings(16'd65535, 16'd1, MIX_REPLACE);
                3: apply_settings(16'd0, 16'd7, MIX_ADD);
                4: apply_settings(16'd300, 16'd0, MIX_REPLACE);
                5: apply_settings(16'd777, 16'd1023, MIX_ADD);
                default: apply_settings(16'($urandom_range(1, 65535)),
                                        16'($urandom_range(1, 512)),
                                        1'($urandom_range(0, 1)));
            endcase
            // the closing phase runs without gaps or stalls
            idle_en = (p < 7);
            run_tone_traffic(PHASE_ITEMS);
        end
    endtask

    // Receiver: stall bursts between runs of free flow.
    initial
    begin : stall_gen
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (idle_en && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                hold = $urandom_range(1, 12) - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                hold = $urandom_range(0, 20);
            end
        end
    end

    function automatic void log_failure(input string msg);
        if (fail_count < 10)
            $display("%0t: %s", $realtime, msg);
        fail_count++;
    endfunction

    always @(posedge clk)
    begin : sample_check
        tone_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
                log_failure($sformatf("unexpected sample %0d last %0b", out_sample, last_out));
            else
            begin
                want = pending_samples.pop_front();
                if (out_sample !== want.sample || last_out !== want.last)
                    log_failure($sformatf("sample mismatch: exp %0d/%0b got %0d/%0b",
                                          want.sample, want.last, out_sample, last_out));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = 1'b0;
        wave_index   = '0;
        wave_value   = '0;
        freq_code    = '0;
        attenuation  = '0;
        mix_in       = '0;
        last_of_call = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_en      = 1'b1;
        fail_count   = 0;
        acc_phase    = '0;
        acc_scale    = '0;
        wave_pos     = '0;
        held_code    = '0;
        cfg_base     = BASE_RESET;
        cfg_length   = 10'(LENGTH_RESET);
        cfg_mix      = MIX_REPLACE;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_wave_fill();
        test_reset_settings();
        test_mix_add();
        test_stale_position();
        test_length_limits();
        test_zero_scale();
        test_random_traffic();

        settle_channel();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
